[rtl/core/midi_file_event_parser_unit_assert.svh]
// ---------------------------------------------------------------------------
// MIDI file event parser: assertion macros
// Shared property forms for the parser's internal checks.
// ---------------------------------------------------------------------------
`ifndef MIDI_FILE_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_FILE_EVENT_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, muted while reset is held.
`define MFEP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is held.
`define MFEP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mfep_pkg.sv]
// ---------------------------------------------------------------------------
// MIDI file event parser: package
// Result record type, parse phase codes, record kinds and error codes.
// ---------------------------------------------------------------------------
package mfep_pkg;

  // Parse phases
  localparam logic [3:0] PH_FTAG   = 4'd0;
  localparam logic [3:0] PH_HLEN   = 4'd1;
  localparam logic [3:0] PH_FMT    = 4'd2;
  localparam logic [3:0] PH_TRKS   = 4'd3;
  localparam logic [3:0] PH_DIV    = 4'd4;
  localparam logic [3:0] PH_TTAG   = 4'd5;
  localparam logic [3:0] PH_TLEN   = 4'd6;
  localparam logic [3:0] PH_DELTA  = 4'd7;
  localparam logic [3:0] PH_STATUS = 4'd8;
  localparam logic [3:0] PH_DATA1  = 4'd9;
  localparam logic [3:0] PH_DATA2  = 4'd10;
  localparam logic [3:0] PH_MTYPE  = 4'd11;
  localparam logic [3:0] PH_MLEN   = 4'd12;
  localparam logic [3:0] PH_MDATA  = 4'd13;
  localparam logic [3:0] PH_DONE   = 4'd14;
  localparam logic [3:0] PH_ERR    = 4'd15;

  // Record kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_TRACK    = 3'd1;
  localparam logic [2:0] KIND_CHANNEL  = 3'd2;
  localparam logic [2:0] KIND_META     = 3'd3;
  localparam logic [2:0] KIND_META_DAT = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_FILE_TAG  = 3'd0;
  localparam logic [2:0] ERR_HDR_LEN   = 3'd1;
  localparam logic [2:0] ERR_TRK_TAG   = 3'd2;
  localparam logic [2:0] ERR_TIME_OVR  = 3'd3;
  localparam logic [2:0] ERR_STATUS    = 3'd4;
  localparam logic [2:0] ERR_END_MISM  = 3'd5;
  localparam logic [2:0] ERR_OVERRUN   = 3'd6;

  // Chunk tags and fixed values
  localparam logic [31:0] TAG_HEADER    = 32'h4D54_6864;
  localparam logic [31:0] TAG_TRACK     = 32'h4D54_726B;
  localparam logic [31:0] HEADER_LEN    = 32'h0000_0006;
  localparam logic [7:0]  META_END_TYPE = 8'h2F;
  localparam logic [3:0]  CMD_META      = 4'hF;
  localparam logic [3:0]  CMD_PROG      = 4'hC;
  localparam logic [3:0]  CMD_PRESS     = 4'hD;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [31:0] delta_time;
    logic [3:0]  command_nibble;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [15:0] file_format;
    logic [15:0] track_total;
    logic [15:0] tick_division;
    logic [31:0] track_length;
    logic [2:0]  error_code;
    logic        meta_last;
  } result_t;

endpackage

[rtl/core/mfep_out_reg.sv]
// ---------------------------------------------------------------------------
// MIDI file event parser: result register
// Holds one result request and parts the input side from the result side.
// ---------------------------------------------------------------------------
module mfep_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mfep_pkg::result_t load_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output mfep_pkg::result_t out_data
);
  import mfep_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  // Room for a new result when empty or draining this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/mfep_parser.sv]
// ---------------------------------------------------------------------------
// MIDI file event parser: parse core
// Parse state registers and the single-pass next-state and record logic.
// ---------------------------------------------------------------------------
`include "midi_file_event_parser_unit_assert.svh"

module mfep_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        file_byte,
  output logic              res_valid,
  output mfep_pkg::result_t res
);
  import mfep_pkg::*;

  logic [3:0]  phase_r,   phase_nxt;
  logic [2:0]  idx_r,     idx_nxt;
  logic [31:0] ws_r,      ws_nxt;
  logic [31:0] tbl_r,     tbl_nxt;
  logic [15:0] tl_r,      tl_nxt;
  logic [7:0]  rs_r,      rs_nxt;
  logic [31:0] acc_r,     acc_nxt;
  logic [7:0]  held_r,    held_nxt;
  logic [7:0]  mbl_r,     mbl_nxt;
  logic        mend_r,    mend_nxt;
  logic [15:0] hfmt_r,    hfmt_nxt;
  logic [15:0] htrk_r,    htrk_nxt;

  logic [31:0] ws_sh;
  logic [2:0]  idx_inc;
  logic [31:0] tbl_dec;
  logic [31:0] tbl_meta;
  logic [7:0]  mbl_dec;
  logic [15:0] tl_dec;
  logic        fail;
  logic [2:0]  fail_code;
  logic        evt_end;
  logic [31:0] evt_left;
  logic        emit_evt;
  logic [2:0]  evt_kind;
  logic [7:0]  evt_d1;
  logic [7:0]  evt_d2;
  logic        evt_last;

  assign ws_sh    = {ws_r[23:0], file_byte};
  assign idx_inc  = idx_r + 3'd1;
  assign tbl_dec  = tbl_r - 32'd1;
  assign tbl_meta = tbl_r - {24'd0, file_byte} - 32'd1;
  assign mbl_dec  = (mbl_r != 8'd0) ? (mbl_r - 8'd1) : 8'd0;
  assign tl_dec   = (tl_r != 16'd0) ? (tl_r - 16'd1) : 16'd0;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    ws_nxt    = ws_r;
    tbl_nxt   = tbl_r;
    tl_nxt    = tl_r;
    rs_nxt    = rs_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    mbl_nxt   = mbl_r;
    mend_nxt  = mend_r;
    hfmt_nxt  = hfmt_r;
    htrk_nxt  = htrk_r;
    fail      = 1'b0;
    fail_code = ERR_FILE_TAG;
    evt_end   = 1'b0;
    evt_left  = tbl_r;
    emit_evt  = 1'b0;
    evt_kind  = KIND_CHANNEL;
    evt_d1    = 8'd0;
    evt_d2    = 8'd0;
    evt_last  = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (step) begin
      unique case (phase_r) inside
        PH_FTAG, PH_HLEN, PH_TTAG: begin
          ws_nxt  = ws_sh;
          idx_nxt = idx_inc;
          if (idx_inc >= 3'd4) begin
            idx_nxt = 3'd0;
            ws_nxt  = 32'd0;
            if (phase_r == PH_FTAG) begin
              phase_nxt = PH_HLEN;
              fail      = (ws_sh != TAG_HEADER);
              fail_code = ERR_FILE_TAG;
            end else if (phase_r == PH_HLEN) begin
              phase_nxt = PH_FMT;
              fail      = (ws_sh != HEADER_LEN);
              fail_code = ERR_HDR_LEN;
            end else begin
              phase_nxt = PH_TLEN;
              fail      = (ws_sh != TAG_TRACK);
              fail_code = ERR_TRK_TAG;
            end
          end
        end
        PH_FMT, PH_TRKS, PH_DIV: begin
          ws_nxt  = ws_sh;
          idx_nxt = idx_inc;
          if (idx_inc >= 3'd2) begin
            idx_nxt = 3'd0;
            ws_nxt  = 32'd0;
            if (phase_r == PH_FMT) begin
              hfmt_nxt  = ws_sh[15:0];
              phase_nxt = PH_TRKS;
            end else if (phase_r == PH_TRKS) begin
              htrk_nxt  = ws_sh[15:0];
              phase_nxt = PH_DIV;
            end else begin
              tl_nxt            = htrk_r;
              phase_nxt         = (htrk_r != 16'd0) ? PH_TTAG : PH_DONE;
              res_valid         = 1'b1;
              res.record_kind   = KIND_HEADER;
              res.file_format   = hfmt_r;
              res.track_total   = htrk_r;
              res.tick_division = ws_sh[15:0];
            end
          end
        end
        PH_TLEN: begin
          ws_nxt  = ws_sh;
          idx_nxt = idx_inc;
          if (idx_inc >= 3'd4) begin
            idx_nxt          = 3'd0;
            ws_nxt           = 32'd0;
            tbl_nxt          = ws_sh;
            rs_nxt           = 8'd0;
            res_valid        = 1'b1;
            res.record_kind  = KIND_TRACK;
            res.track_length = ws_sh;
            evt_end          = 1'b1;
            evt_left         = ws_sh;
          end
        end
        PH_DELTA: begin
          idx_nxt = 3'd1;
          acc_nxt = (idx_r == 3'd0) ? {25'd0, file_byte[6:0]}
                                    : {acc_r[24:0], file_byte[6:0]};
          tbl_nxt = tbl_dec;
          if (tbl_r == 32'd0 || tbl_dec == 32'd0) begin
            fail      = 1'b1;
            fail_code = ERR_TIME_OVR;
          end else if (!file_byte[7]) begin
            idx_nxt   = 3'd0;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS, PH_DATA1, PH_MTYPE, PH_DATA2: begin
          tbl_nxt = tbl_dec;
          if (tbl_r == 32'd0 && !(phase_r == PH_STATUS && !file_byte[7])) begin
            fail      = 1'b1;
            fail_code = ERR_OVERRUN;
          end else if (phase_r == PH_STATUS && file_byte[7]) begin
            rs_nxt    = file_byte;
            phase_nxt = (file_byte[7:4] == CMD_META) ? PH_MTYPE : PH_DATA1;
          end else if (phase_r == PH_STATUS && !rs_r[7]) begin
            fail      = 1'b1;
            fail_code = ERR_STATUS;
          end else if (tbl_r == 32'd0) begin
            fail      = 1'b1;
            fail_code = ERR_OVERRUN;
          end else if (phase_r == PH_DATA2) begin
            emit_evt = 1'b1;
            evt_d1   = held_r;
            evt_d2   = file_byte;
            evt_end  = 1'b1;
            evt_left = tbl_dec;
          end else if (phase_r == PH_MTYPE || rs_r[7:4] == CMD_META) begin
            held_nxt  = file_byte;
            mend_nxt  = (file_byte == META_END_TYPE);
            phase_nxt = PH_MLEN;
          end else begin
            held_nxt = file_byte;
            if (rs_r[7:4] == CMD_PROG || rs_r[7:4] == CMD_PRESS) begin
              emit_evt = 1'b1;
              evt_d1   = file_byte;
              evt_end  = 1'b1;
              evt_left = tbl_dec;
            end else begin
              phase_nxt = PH_DATA2;
            end
          end
        end
        PH_MLEN: begin
          tbl_nxt = tbl_meta;
          mbl_nxt = file_byte;
          if ({24'd0, file_byte} >= tbl_r) begin
            fail      = 1'b1;
            fail_code = ERR_OVERRUN;
          end else if (mend_r != (tbl_meta == 32'd0)) begin
            fail      = 1'b1;
            fail_code = ERR_END_MISM;
          end else begin
            emit_evt = 1'b1;
            evt_kind = KIND_META;
            evt_d1   = held_r;
            evt_d2   = file_byte;
            if (file_byte == 8'd0) begin
              evt_end  = 1'b1;
              evt_left = tbl_meta;
            end else begin
              phase_nxt = PH_MDATA;
            end
          end
        end
        PH_MDATA: begin
          mbl_nxt  = mbl_dec;
          emit_evt = 1'b1;
          evt_kind = KIND_META_DAT;
          evt_d1   = file_byte;
          evt_last = (mbl_dec == 8'd0);
          evt_end  = (mbl_dec == 8'd0);
          evt_left = tbl_r;
        end
        PH_DONE, PH_ERR: begin
          // drop the byte
        end
        default: begin
        end
      endcase

      if (emit_evt) begin
        res_valid          = 1'b1;
        res.record_kind    = evt_kind;
        res.delta_time     = acc_r;
        res.command_nibble = rs_r[7:4];
        res.channel        = rs_r[3:0];
        res.first_data     = evt_d1;
        res.second_data    = evt_d2;
        res.meta_last      = evt_last;
      end

      // Close the event, and the track when its bytes are used up
      if (evt_end) begin
        idx_nxt = 3'd0;
        if (evt_left == 32'd0) begin
          tl_nxt    = tl_dec;
          phase_nxt = (tl_dec != 16'd0) ? PH_TTAG : PH_DONE;
        end else begin
          phase_nxt = PH_DELTA;
        end
      end

      if (fail) begin
        phase_nxt       = PH_ERR;
        res_valid       = 1'b1;
        res             = '0;
        res.record_kind = KIND_ERROR;
        res.error_code  = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FTAG;
      idx_r   <= 3'd0;
      ws_r    <= 32'd0;
      tbl_r   <= 32'd0;
      tl_r    <= 16'd0;
      rs_r    <= 8'd0;
      acc_r   <= 32'd0;
      held_r  <= 8'd0;
      mbl_r   <= 8'd0;
      mend_r  <= 1'b0;
      hfmt_r  <= 16'd0;
      htrk_r  <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      ws_r    <= ws_nxt;
      tbl_r   <= tbl_nxt;
      tl_r    <= tl_nxt;
      rs_r    <= rs_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      mbl_r   <= mbl_nxt;
      mend_r  <= mend_nxt;
      hfmt_r  <= hfmt_nxt;
      htrk_r  <= htrk_nxt;
    end
  end

  `MFEP_ASSERT_NEXT(a_err_sticky, clk, rst_n, phase_r == PH_ERR, phase_r == PH_ERR, "error phase left")
  `MFEP_ASSERT_NEXT(a_err_rec_phase, clk, rst_n, res_valid && res.record_kind == KIND_ERROR, phase_r == PH_ERR, "error record without error phase")
  `MFEP_ASSERT_NOW(a_quiet_after_end, clk, rst_n, phase_r == PH_DONE || phase_r == PH_ERR, !res_valid, "record after parse end")
  `MFEP_ASSERT_NOW(a_event_has_bytes, clk, rst_n, phase_r == PH_DELTA || phase_r == PH_STATUS, tbl_r != 32'd0, "event phase with empty track")

endmodule

[rtl/core/midi_file_event_parser_unit.sv]
// ---------------------------------------------------------------------------
// MIDI file event parser unit
// Parses a standard MIDI file one byte per request and reports header,
// track start, channel event, meta event, meta data and error records.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    in_file_byte (8)
//   out_      output     out_valid/out_ready  twelve record fields
//
// One byte request is taken per cycle while the result register has room;
// its record, if any, appears there on the next cycle. The parse step is a
// single pass of logic from the parse state registers to the result register.
// in_ready is high whenever the result register is empty or drains in the
// same cycle, so a stalled result side holds the input only while a record
// is waiting. rst_n (synchronous) returns the parser to the file header tag.
// ---------------------------------------------------------------------------
module midi_file_event_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_record_kind,
  output logic [31:0] out_delta_time,
  output logic [3:0]  out_command_nibble,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_first_data,
  output logic [7:0]  out_second_data,
  output logic [15:0] out_file_format,
  output logic [15:0] out_track_total,
  output logic [15:0] out_tick_division,
  output logic [31:0] out_track_length,
  output logic [2:0]  out_error_code,
  output logic        out_meta_last
);
  import mfep_pkg::*;

  logic    space;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // Take a byte whenever the result register has room for its record
  assign in_ready = space;
  assign accept   = in_valid && space;

  mfep_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .file_byte (in_file_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the record until the result side takes it
  mfep_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_record_kind    = out_data.record_kind;
  assign out_delta_time     = out_data.delta_time;
  assign out_command_nibble = out_data.command_nibble;
  assign out_channel        = out_data.channel;
  assign out_first_data     = out_data.first_data;
  assign out_second_data    = out_data.second_data;
  assign out_file_format    = out_data.file_format;
  assign out_track_total    = out_data.track_total;
  assign out_tick_division  = out_data.tick_division;
  assign out_track_length   = out_data.track_length;
  assign out_error_code     = out_data.error_code;
  assign out_meta_last      = out_data.meta_last;

endmodule

[sim/midi_file_event_parser_unit_test.sv]
// ---------------------------------------------------------------------------
// MIDI file event parser unit: self-checking testbench
// Streams one MIDI file into the parser a byte request at a time. The file
// opens with hand-made tracks that reach every command and the corner cases
// of delta time, running status and meta events. Random tracks follow, and
// the file closes cleanly or with one broken track. A byte-level parse model
// predicts every record, and each record is checked field by field.
// ---------------------------------------------------------------------------
module midi_file_event_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfep_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_GAP       = 16;
  localparam int TRAILING_JUNK = 16;

  // Tracks that complete cleanly before the closing stage
  localparam int DIRECTED_TRACKS = 3;
  localparam int HOLD_TRACKS     = 2;
  localparam int RANDOM_TRACKS   = 12;
  localparam int CLEAN_TRACKS    = DIRECTED_TRACKS + HOLD_TRACKS + RANDOM_TRACKS;

  // A byte with its top bit set is a status byte
  localparam logic [7:0] STATUS_MIN = 8'h80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_file_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_record_kind;
  logic [31:0] out_delta_time;
  logic [3:0]  out_command_nibble;
  logic [3:0]  out_channel;
  logic [7:0]  out_first_data;
  logic [7:0]  out_second_data;
  logic [15:0] out_file_format;
  logic [15:0] out_track_total;
  logic [15:0] out_tick_division;
  logic [31:0] out_track_length;
  logic [2:0]  out_error_code;
  logic        out_meta_last;

  midi_file_event_parser_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_file_byte       (in_file_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_kind    (out_record_kind),
    .out_delta_time     (out_delta_time),
    .out_command_nibble (out_command_nibble),
    .out_channel        (out_channel),
    .out_first_data     (out_first_data),
    .out_second_data    (out_second_data),
    .out_file_format    (out_file_format),
    .out_track_total    (out_track_total),
    .out_tick_division  (out_tick_division),
    .out_track_length   (out_track_length),
    .out_error_code     (out_error_code),
    .out_meta_last      (out_meta_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // -------------------------------------------------------------------------
  // Parse model state. Starts at the reset values and is stepped once for
  // every byte request that the parser accepts.
  // -------------------------------------------------------------------------
  logic [3:0]  parse_phase_m   = PH_FTAG;
  logic [2:0]  field_index_m   = '0;
  logic [31:0] shift_word_m    = '0;
  logic [31:0] track_left_m    = '0;
  logic [15:0] tracks_to_go_m  = '0;
  logic [7:0]  run_status_m    = '0;
  logic [31:0] delta_acc_m     = '0;
  logic [7:0]  held_byte_m     = '0;
  logic [7:0]  meta_left_m     = '0;
  logic        meta_is_end_m   = 1'b0;
  logic [15:0] hdr_format_m    = '0;
  logic [15:0] hdr_tracks_m    = '0;
  logic        error_stuck_m   = 1'b0;

  result_t expected_records[$];
  result_t next_record;
  int      mismatch_count = 0;
  int      cycle_count    = 0;

  // Stimulus controls shared by the test tasks and the result sink
  logic [7:0]  track_body[$];
  logic [7:0]  gen_status     = '0;
  bit          sender_burst   = 1'b0;
  bit          receiver_burst = 1'b0;
  bit          hold_pending   = 1'b0;
  bit          ending_clean;
  logic [2:0]  ending_code;

  // Queue a predicted record behind those already waiting.
  function automatic void expect_record(input result_t r);
    expected_records.insert(expected_records.size(), r);
  endfunction

  // Shift one byte into the gathered word; true once nbytes have arrived.
  function automatic bit gather_byte(input logic [7:0] b, input int nbytes);
    shift_word_m  = {shift_word_m[23:0], b};
    field_index_m = field_index_m + 3'd1;
    if (field_index_m >= nbytes) begin
      field_index_m = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit take_track_byte();
    if (track_left_m == 0) return 1'b0;
    track_left_m = track_left_m - 32'd1;
    return 1'b1;
  endfunction

  function automatic void close_track();
    if (tracks_to_go_m != 0) tracks_to_go_m = tracks_to_go_m - 16'd1;
    parse_phase_m = (tracks_to_go_m != 0) ? PH_TTAG : PH_DONE;
  endfunction

  function automatic void close_event();
    field_index_m = '0;
    if (track_left_m == 0) close_track();
    else parse_phase_m = PH_DELTA;
  endfunction

  function automatic result_t event_record(input logic [2:0] kind);
    result_t r;
    r = '0;
    r.record_kind    = kind;
    r.delta_time     = delta_acc_m;
    r.command_nibble = run_status_m[7:4];
    r.channel        = run_status_m[3:0];
    return r;
  endfunction

  // Latch the parse error; every later byte is dropped.
  function automatic void raise_parse_error(input logic [2:0] code);
    result_t r;
    r = '0;
    parse_phase_m = PH_ERR;
    error_stuck_m = 1'b1;
    r.record_kind = KIND_ERROR;
    r.error_code  = code;
    expect_record(r);
  endfunction

  function automatic void take_first_data(input logic [7:0] b);
    result_t r;
    if (!take_track_byte()) begin
      raise_parse_error(ERR_OVERRUN);
      return;
    end
    held_byte_m = b;
    if (run_status_m[7:4] == CMD_PROG || run_status_m[7:4] == CMD_PRESS) begin
      r = event_record(KIND_CHANNEL);
      r.first_data = b;
      expect_record(r);
      close_event();
    end else begin
      parse_phase_m = PH_DATA2;
    end
  endfunction

  function automatic void take_meta_type(input logic [7:0] b);
    if (!take_track_byte()) begin
      raise_parse_error(ERR_OVERRUN);
      return;
    end
    held_byte_m   = b;
    meta_is_end_m = (b == META_END_TYPE);
    parse_phase_m = PH_MLEN;
  endfunction

  // Advance the parse model by one accepted file byte and queue its record.
  function automatic void parse_file_byte(input logic [7:0] b);
    result_t r;
    if (error_stuck_m || parse_phase_m == PH_ERR || parse_phase_m == PH_DONE) return;
    case (parse_phase_m)
      PH_FTAG: begin
        if (gather_byte(b, 4)) begin
          if (shift_word_m != TAG_HEADER) raise_parse_error(ERR_FILE_TAG);
          else begin
            shift_word_m  = '0;
            parse_phase_m = PH_HLEN;
          end
        end
      end
      PH_HLEN: begin
        if (gather_byte(b, 4)) begin
          if (shift_word_m != HEADER_LEN) raise_parse_error(ERR_HDR_LEN);
          else begin
            shift_word_m  = '0;
            parse_phase_m = PH_FMT;
          end
        end
      end
      PH_FMT: begin
        if (gather_byte(b, 2)) begin
          hdr_format_m  = shift_word_m[15:0];
          shift_word_m  = '0;
          parse_phase_m = PH_TRKS;
        end
      end
      PH_TRKS: begin
        if (gather_byte(b, 2)) begin
          hdr_tracks_m  = shift_word_m[15:0];
          shift_word_m  = '0;
          parse_phase_m = PH_DIV;
        end
      end
      PH_DIV: begin
        if (gather_byte(b, 2)) begin
          r = '0;
          r.record_kind   = KIND_HEADER;
          r.file_format   = hdr_format_m;
          r.track_total   = hdr_tracks_m;
          r.tick_division = shift_word_m[15:0];
          expect_record(r);
          shift_word_m   = '0;
          tracks_to_go_m = hdr_tracks_m;
          parse_phase_m  = (tracks_to_go_m != 0) ? PH_TTAG : PH_DONE;
        end
      end
      PH_TTAG: begin
        if (gather_byte(b, 4)) begin
          if (shift_word_m != TAG_TRACK) raise_parse_error(ERR_TRK_TAG);
          else begin
            shift_word_m  = '0;
            parse_phase_m = PH_TLEN;
          end
        end
      end
      PH_TLEN: begin
        if (gather_byte(b, 4)) begin
          track_left_m = shift_word_m;
          shift_word_m = '0;
          run_status_m = '0;
          r = '0;
          r.record_kind  = KIND_TRACK;
          r.track_length = track_left_m;
          expect_record(r);
          // An empty track ends on its own length word
          if (track_left_m == 0) close_track();
          else begin
            field_index_m = '0;
            parse_phase_m = PH_DELTA;
          end
        end
      end
      PH_DELTA: begin
        if (field_index_m == 0) begin
          delta_acc_m   = '0;
          field_index_m = 3'd1;
        end
        delta_acc_m = (delta_acc_m << 7) + {25'd0, b[6:0]};
        // The delta may never use up the track, not even on its last byte
        if (!take_track_byte()) raise_parse_error(ERR_TIME_OVR);
        else if (track_left_m == 0) raise_parse_error(ERR_TIME_OVR);
        else if (!b[7]) begin
          field_index_m = '0;
          parse_phase_m = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (!take_track_byte()) raise_parse_error(ERR_OVERRUN);
          else begin
            run_status_m  = b;
            parse_phase_m = (b[7:4] == CMD_META) ? PH_MTYPE : PH_DATA1;
          end
        end else if (run_status_m < STATUS_MIN) begin
          raise_parse_error(ERR_STATUS);
        end else if (run_status_m[7:4] == CMD_META) begin
          take_meta_type(b);
        end else begin
          take_first_data(b);
        end
      end
      PH_DATA1: take_first_data(b);
      PH_DATA2: begin
        if (!take_track_byte()) raise_parse_error(ERR_OVERRUN);
        else begin
          r = event_record(KIND_CHANNEL);
          r.first_data  = held_byte_m;
          r.second_data = b;
          expect_record(r);
          close_event();
        end
      end
      PH_MTYPE: take_meta_type(b);
      PH_MLEN: begin
        if (!take_track_byte()) raise_parse_error(ERR_OVERRUN);
        else if ({24'd0, b} > track_left_m) raise_parse_error(ERR_OVERRUN);
        else begin
          track_left_m = track_left_m - {24'd0, b};
          // End of track meta exactly when the track is used up
          if (meta_is_end_m != (track_left_m == 0)) raise_parse_error(ERR_END_MISM);
          else begin
            r = event_record(KIND_META);
            r.first_data  = held_byte_m;
            r.second_data = b;
            expect_record(r);
            meta_left_m = b;
            if (b == 0) close_event();
            else parse_phase_m = PH_MDATA;
          end
        end
      end
      PH_MDATA: begin
        if (meta_left_m != 0) meta_left_m = meta_left_m - 8'd1;
        r = event_record(KIND_META_DAT);
        r.first_data = b;
        r.meta_last  = (meta_left_m == 0);
        expect_record(r);
        if (meta_left_m == 0) close_event();
      end
      default: ;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------

  // Offer one byte request, hold it until taken, then draw the idle gap
  // before the next one.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid     <= 1'b1;
    in_file_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_file_byte(b);
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid once no further request follows at once.
  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_word(input logic [31:0] w, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(w[8 * i +: 8]);
  endtask

  // Frame the collected body as a track chunk with the given length word.
  task automatic send_track(input logic [31:0] len);
    send_word(TAG_TRACK, 4);
    send_word(len, 4);
    foreach (track_body[i]) send_byte(track_body[i]);
    track_body.delete();
    gen_status = '0;
  endtask

  task automatic send_junk(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // -------------------------------------------------------------------------
  // Track body generation. gen_status follows the running status that the
  // parser will hold, so that status bytes can be left out.
  // -------------------------------------------------------------------------
  function automatic void put_body(input logic [7:0] b);
    track_body.insert(track_body.size(), b);
  endfunction

  function automatic int delta_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 1;
    if (r < 8) return 2;
    if (r == 8) return 3;
    return $urandom_range(4, 5);
  endfunction

  function automatic void add_delta(input int nbytes);
    for (int i = 1; i < nbytes; i++) put_body({1'b1, 7'($urandom_range(0, 127))});
    put_body({1'b0, 7'($urandom_range(0, 127))});
  endfunction

  function automatic logic [7:0] plain_meta_type();
    logic [7:0] t;
    do begin
      t = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 127));
    end while (t == META_END_TYPE);
    return t;
  endfunction

  function automatic void add_channel_event();
    logic [3:0] cmd;
    logic [7:0] first;
    if (gen_status[7] && gen_status[7:4] != CMD_META && $urandom_range(0, 2) == 0) begin
      // Running status: the data byte must not look like a status
      cmd   = gen_status[7:4];
      first = 8'($urandom_range(0, 127));
    end else begin
      cmd        = 4'($urandom_range(8, 14));
      gen_status = {cmd, 4'($urandom_range(0, 15))};
      put_body(gen_status);
      first = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom_range(0, 127));
    end
    put_body(first);
    if (cmd != CMD_PROG && cmd != CMD_PRESS) put_body(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_meta_event(input logic [7:0] mtype, input int mlen);
    logic [7:0] status_byte;
    if (!(gen_status[7:4] == CMD_META && !mtype[7] && $urandom_range(0, 2) == 0)) begin
      status_byte = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom_range(8'hF0, 8'hFE));
      put_body(status_byte);
      gen_status = status_byte;
    end
    put_body(mtype);
    put_body(8'(mlen));
    repeat (mlen) put_body(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_random_event();
    add_delta(delta_length());
    if ($urandom_range(0, 2) != 0) add_channel_event();
    else add_meta_event(plain_meta_type(), $urandom_range(0, 6));
  endfunction

  // Close a track with an end of track meta or a channel event that uses
  // up the last byte.
  function automatic void add_track_end();
    add_delta(delta_length());
    if ($urandom_range(0, 1) == 0) add_meta_event(META_END_TYPE, $urandom_range(0, 3));
    else add_channel_event();
  endfunction

  task automatic send_random_track();
    int count;
    count = $urandom_range(1, 12);
    repeat (count - 1) add_random_event();
    add_track_end();
    send_track(track_body.size());
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Header chunk: the track count decides whether the file ends cleanly or
  // runs into the broken track at the close.
  task automatic test_file_header();
    logic [15:0] fmt;
    logic [15:0] tracks;
    logic [15:0] division;
    int pick;
    ending_clean = ($urandom_range(0, 5) == 0);
    ending_code  = 3'($urandom_range(ERR_TRK_TAG, ERR_OVERRUN));
    pick     = $urandom_range(0, 2);
    fmt      = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    pick     = $urandom_range(0, 2);
    division = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    pick     = $urandom_range(0, 3);
    if (ending_clean) tracks = 16'(CLEAN_TRACKS);
    else if (pick == 0) tracks = 16'hFFFF;
    else if (pick == 1) tracks = 16'(CLEAN_TRACKS + 1);
    else tracks = 16'($urandom_range(CLEAN_TRACKS + 1, 65535));
    send_word(TAG_HEADER, 4);
    send_word(HEADER_LEN, 4);
    send_word({16'd0, fmt}, 2);
    send_word({16'd0, tracks}, 2);
    send_word({16'd0, division}, 2);
  endtask

  // Hand-made tracks: every command, data and delta extremes, running status
  // for channel and meta events, system statuses, an empty track and a
  // track closed by a channel event.
  task automatic test_directed_events();
    track_body = '{
      8'h00, 8'h80, 8'h00, 8'h00,               // note off, zero data
      8'h7F, 8'h9F, 8'h7F, 8'h7F,               // widest one-byte delta
      8'h81, 8'h00, 8'h7F, 8'h7F,               // two-byte delta, running status
      8'hFF, 8'hFF, 8'hFF, 8'h7F,               // largest four-byte delta
      8'hA5, 8'h12, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,        // five-byte delta wraps
      8'hB3, 8'h80, 8'h40,                      // data byte with top bit set
      8'h00, 8'hC7, 8'hFF,                      // one data byte commands
      8'h00, 8'hD0, 8'h00,
      8'h00, 8'h3C,                             // running one-byte command
      8'h00, 8'hEA, 8'h00, 8'h7F,
      8'h00, 8'hF0, 8'h01, 8'h02, 8'hAA, 8'hBB, // system status as meta
      8'h00, 8'h05, 8'h00,                      // running meta, zero length
      8'h00, 8'hFF, 8'h81, 8'h01, 8'hFF,        // meta type with top bit set
      8'h00, 8'hF7, 8'h7F, 8'h00,
      8'h00, 8'hFF, 8'h2F, 8'h00                // end of track
    };
    send_track(track_body.size());
    send_track(32'd0);
    track_body = '{8'h00, 8'h90, 8'h3C, 8'h40, 8'h10, 8'h80, 8'h3C, 8'h00};
    send_track(track_body.size());
  endtask

  // Hold the requests back until every queued record has drained.
  task automatic test_drain_pause();
    release_input();
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  // The sink stops for a long stretch while requests keep coming, so the
  // result register fills and in_ready must drop.
  task automatic test_receiver_hold();
    hold_pending = 1'b1;
    sender_burst = 1'b1;
    repeat (HOLD_TRACKS) send_random_track();
    sender_burst = 1'b0;
  endtask

  // Random tracks, with stretches where one side or both never idle.
  task automatic test_random_tracks();
    repeat (RANDOM_TRACKS) begin
      sender_burst   = ($urandom_range(0, 4) == 0);
      receiver_burst = ($urandom_range(0, 4) == 0);
      send_random_track();
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  // Close the file cleanly or with one broken track, then feed bytes that
  // the parser must drop.
  task automatic test_file_ending();
    logic [31:0] len;
    logic [31:0] bad_tag;
    int          mlen;
    int          count;
    if (!ending_clean) begin
      len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0000_0100);
      case (ending_code)
        ERR_TRK_TAG: begin
          bad_tag = TAG_TRACK ^ ({24'd0, 8'($urandom_range(1, 255))}
                                 << (8 * $urandom_range(0, 3)));
          send_word(bad_tag, 4);
          send_word($urandom, 4);
        end
        ERR_TIME_OVR: begin
          // The track ends on a delta byte
          count = $urandom_range(0, 3);
          repeat (count) add_random_event();
          add_delta(delta_length());
          send_track(track_body.size());
        end
        ERR_STATUS: begin
          // Fresh track, no running status yet, data byte where status is due
          add_delta(delta_length());
          put_body(8'($urandom_range(0, 127)));
          send_track(len);
        end
        ERR_END_MISM: begin
          if ($urandom_range(0, 1) == 0) begin
            // End of track meta with bytes still left
            add_delta(delta_length());
            add_meta_event(META_END_TYPE, $urandom_range(0, 3));
            send_track(($urandom_range(0, 1) == 0) ? len
                       : track_body.size() + $urandom_range(1, 40));
          end else begin
            // Any other meta that uses up the track
            count = $urandom_range(0, 3);
            repeat (count) add_random_event();
            add_delta(delta_length());
            add_meta_event(plain_meta_type(), $urandom_range(0, 4));
            send_track(track_body.size());
          end
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            // Meta length larger than the bytes left
            mlen = $urandom_range(1, 255);
            add_delta(delta_length());
            put_body(8'hFF);
            put_body(plain_meta_type());
            put_body(8'(mlen));
            repeat ($urandom_range(0, mlen - 1)) put_body(8'($urandom_range(0, 255)));
            send_track(track_body.size());
          end else begin
            // Status byte takes the last track byte, its data overruns
            add_delta(delta_length());
            put_body({4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))});
            len = track_body.size();
            put_body(8'($urandom_range(0, 127)));
            put_body(8'($urandom_range(0, 127)));
            send_track(len);
          end
        end
      endcase
    end
    send_junk(TRAILING_JUNK);
  endtask

  // -------------------------------------------------------------------------
  // Result sink: a random stall before each record, or the long hold once.
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each record taken against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("record_kind: expected none, got 0x%0h", out_record_kind);
        mismatch_count++;
      end else begin
        next_record = expected_records.pop_front();
        check_field("record_kind", 32'(next_record.record_kind), 32'(out_record_kind));
        check_field("delta_time", next_record.delta_time, out_delta_time);
        check_field("command_nibble", 32'(next_record.command_nibble),
                    32'(out_command_nibble));
        check_field("channel", 32'(next_record.channel), 32'(out_channel));
        check_field("first_data", 32'(next_record.first_data), 32'(out_first_data));
        check_field("second_data", 32'(next_record.second_data), 32'(out_second_data));
        check_field("file_format", 32'(next_record.file_format), 32'(out_file_format));
        check_field("track_total", 32'(next_record.track_total), 32'(out_track_total));
        check_field("tick_division", 32'(next_record.tick_division),
                    32'(out_tick_division));
        check_field("track_length", next_record.track_length, out_track_length);
        check_field("error_code", 32'(next_record.error_code), 32'(out_error_code));
        check_field("meta_last", 32'(next_record.meta_last), 32'(out_meta_last));
      end
    end
  end

  // Abandon a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** midi_file_event_parser_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_file_header();
    test_directed_events();
    test_drain_pause();
    test_receiver_hold();
    test_random_tracks();
    test_file_ending();
    release_input();
    receiver_burst = 1'b1;
    while (expected_records.size() != 0) @(posedge clk);
    // Let any stray record surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** midi_file_event_parser_unit: PASSED **");
    end else begin
      $display("** midi_file_event_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mfep_pkg.sv
rtl/core/mfep_out_reg.sv
rtl/core/mfep_parser.sv
rtl/core/midi_file_event_parser_unit.sv
sim/midi_file_event_parser_unit_test.sv
